// File: src/sha1_pkg.sv
// Shared types and constants for the SHA-1 message hasher.
// No dependencies; used by sha1_ctrl, sha1_dp, sha1_message_hasher and its testbench.
`default_nettype none

package sha1_pkg;

  // Source of the byte shifted into the block register
  typedef enum logic [1:0] {
    SEL_DATA,
    SEL_PAD,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_e;

  // Round group, picks the mixing function and the round constant
  typedef enum logic [1:0] {
    STAGE_CH,
    STAGE_PAR1,
    STAGE_MAJ,
    STAGE_PAR2
  } round_stage_e;

  // Kind codes on the input channel
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  localparam int unsigned NUM_HASH_WORDS = 5;
  localparam int unsigned NUM_ROUNDS     = 80;

  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  FILL_LAST = 6'd63;  // last byte slot of a block
  localparam logic [5:0]  FILL_LEN  = 6'd55;  // last slot before the length field
  localparam logic [2:0]  LEN_LAST  = 3'd7;
  localparam logic [2:0]  WORD_LAST = 3'd4;
  localparam logic [6:0]  ROUND_LAST = 7'd79;

  localparam logic [31:0] HASH_INIT [NUM_HASH_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // Commands from the controller to the datapath
  typedef struct packed {
    logic         shift;      // shift one byte into the block
    byte_sel_e    sel;
    logic         count_inc;  // message byte, bump the length
    logic         load_work;  // copy hash words into working variables
    logic         round_en;   // run one compression round
    round_stage_e stage;
    logic         add_en;     // fold working variables into the hash
    logic         clr_hash;   // restart for the next message
    logic [2:0]   len_idx;
    logic [2:0]   out_idx;
  } cmd_t;

  function automatic logic [31:0] round_const(round_stage_e stage);
    logic [31:0] k;
    unique case (stage)
      STAGE_CH:   k = 32'h5A827999;
      STAGE_PAR1: k = 32'h6ED9EBA1;
      STAGE_MAJ:  k = 32'h8F1BBCDC;
      default:    k = 32'hCA62C1D6;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// File: src/sha1_ctrl.sv
// Controller of the SHA-1 hasher: sequences bytes, padding, rounds and output.
// Depends on sha1_pkg.
`default_nettype none

module sha1_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          kind_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire logic [5:0]    fill_i,
  output sha1_pkg::cmd_t     cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ROUND = 3'd1;
  localparam logic [2:0] ST_ADD   = 3'd2;
  localparam logic [2:0] ST_PAD   = 3'd3;
  localparam logic [2:0] ST_LEN   = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0] state_q, state_d;
  logic [6:0] round_q, round_d;
  logic [2:0] len_q, len_d;
  logic [2:0] out_q, out_d;
  logic       first_q, first_d;   // next padding byte is the 0x80 marker
  logic       padding_q, padding_d; // padding resumes after this compression
  logic       final_q, final_d;   // this compression is the last of the message
  logic       in_acc, out_acc;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_o && out_ready_i;

  // Next state and commands
  always_comb begin
    state_d   = state_q;
    round_d   = round_q;
    len_d     = len_q;
    out_d     = out_q;
    first_d   = first_q;
    padding_d = padding_q;
    final_d   = final_q;

    cmd_o           = '0;
    cmd_o.sel       = sha1_pkg::SEL_DATA;
    cmd_o.len_idx   = len_q;
    cmd_o.out_idx   = out_q;
    if (round_q < 7'd20) begin
      cmd_o.stage = sha1_pkg::STAGE_CH;
    end else if (round_q < 7'd40) begin
      cmd_o.stage = sha1_pkg::STAGE_PAR1;
    end else if (round_q < 7'd60) begin
      cmd_o.stage = sha1_pkg::STAGE_MAJ;
    end else begin
      cmd_o.stage = sha1_pkg::STAGE_PAR2;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (kind_i == sha1_pkg::KIND_BYTE) begin
            cmd_o.shift     = 1'b1;
            cmd_o.count_inc = 1'b1;
            if (fill_i == sha1_pkg::FILL_LAST) begin
              cmd_o.load_work = 1'b1;
              padding_d       = 1'b0;
              final_d         = 1'b0;
              state_d         = ST_ROUND;
            end
          end else begin
            first_d = 1'b1;
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd_o.shift = 1'b1;
        cmd_o.sel   = first_q ? sha1_pkg::SEL_PAD : sha1_pkg::SEL_ZERO;
        first_d     = 1'b0;
        if (fill_i == sha1_pkg::FILL_LEN) begin
          len_d   = '0;
          state_d = ST_LEN;
        end else if (fill_i == sha1_pkg::FILL_LAST) begin
          cmd_o.load_work = 1'b1;
          padding_d       = 1'b1;
          state_d         = ST_ROUND;
        end
      end
      ST_LEN: begin
        cmd_o.shift = 1'b1;
        cmd_o.sel   = sha1_pkg::SEL_LEN;
        len_d       = len_q + 3'd1;
        if (len_q == sha1_pkg::LEN_LAST) begin
          cmd_o.load_work = 1'b1;
          padding_d       = 1'b0;
          final_d         = 1'b1;
          state_d         = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd_o.round_en = 1'b1;
        if (round_q == sha1_pkg::ROUND_LAST) begin
          round_d = '0;
          state_d = ST_ADD;
        end else begin
          round_d = round_q + 7'd1;
        end
      end
      ST_ADD: begin
        cmd_o.add_en = 1'b1;
        if (final_q) begin
          out_d   = '0;
          state_d = ST_EMIT;
        end else if (padding_q) begin
          padding_d = 1'b0;
          first_d   = 1'b0;
          state_d   = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (out_q == sha1_pkg::WORD_LAST) begin
            cmd_o.clr_hash = 1'b1;
            final_d        = 1'b0;
            state_d        = ST_IDLE;
          end else begin
            out_d = out_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      round_q   <= '0;
      len_q     <= '0;
      out_q     <= '0;
      first_q   <= 1'b0;
      padding_q <= 1'b0;
      final_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      round_q   <= round_d;
      len_q     <= len_d;
      out_q     <= out_d;
      first_q   <= first_d;
      padding_q <= padding_d;
      final_q   <= final_d;
    end
  end

endmodule

`default_nettype wire

// File: src/sha1_dp.sv
// Datapath of the SHA-1 hasher: block/schedule register, round unit, hash words.
// Depends on sha1_pkg; driven by sha1_ctrl.
`default_nettype none

module sha1_dp (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire sha1_pkg::cmd_t cmd_i,
  input  wire logic [7:0]     data_byte_i,
  output logic [5:0]          fill_o,
  output logic [31:0]         digest_word_o
);

  logic [511:0] blk_q;          // word 0 in the top bits
  logic [5:0]   fill_q;
  logic [60:0]  count_q;
  logic [31:0]  hash_q [sha1_pkg::NUM_HASH_WORDS];
  logic [31:0]  a_q, b_q, c_q, d_q, e_q;

  logic [63:0]  bit_count;
  logic [7:0]   len_byte;
  logic [7:0]   in_byte;
  logic [31:0]  w0, w_new, w_new_x, f, t;

  assign fill_o    = fill_q;
  assign bit_count = {count_q, 3'b000};
  assign len_byte  = 8'(bit_count >> {~cmd_i.len_idx, 3'b000});

  // Byte source
  always_comb begin
    case (cmd_i.sel)
      sha1_pkg::SEL_DATA: in_byte = data_byte_i;
      sha1_pkg::SEL_PAD:  in_byte = sha1_pkg::PAD_BYTE;
      sha1_pkg::SEL_LEN:  in_byte = len_byte;
      default:            in_byte = 8'h00;
    endcase
  end

  // Message schedule: w[16+] from words 0, 2, 8 and 13 of the window
  assign w0      = blk_q[511:480];
  assign w_new_x = blk_q[95:64] ^ blk_q[255:224] ^ blk_q[447:416] ^ w0;
  assign w_new   = {w_new_x[30:0], w_new_x[31]};

  // Round function
  always_comb begin
    case (cmd_i.stage)
      sha1_pkg::STAGE_CH:  f = (b_q & c_q) | (~b_q & d_q);
      sha1_pkg::STAGE_MAJ: f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      default:             f = b_q ^ c_q ^ d_q;
    endcase
  end
  assign t = {a_q[26:0], a_q[31:27]} + f + e_q + sha1_pkg::round_const(cmd_i.stage) + w0;

  // Block register, shared by byte loading and the schedule
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      blk_q <= {blk_q[503:0], in_byte};
    end else if (cmd_i.round_en) begin
      blk_q <= {blk_q[479:0], w_new};
    end
  end

  // Working variables
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_work) begin
      a_q <= hash_q[0];
      b_q <= hash_q[1];
      c_q <= hash_q[2];
      d_q <= hash_q[3];
      e_q <= hash_q[4];
    end else if (cmd_i.round_en) begin
      a_q <= t;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end
  end

  // Fill, length and hash words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      count_q <= '0;
      hash_q  <= sha1_pkg::HASH_INIT;
    end else begin
      if (cmd_i.shift) begin
        fill_q <= fill_q + 6'd1;
      end
      if (cmd_i.clr_hash) begin
        count_q <= '0;
        hash_q  <= sha1_pkg::HASH_INIT;
      end else begin
        if (cmd_i.count_inc) begin
          count_q <= count_q + 61'd1;
        end
        if (cmd_i.add_en) begin
          hash_q[0] <= hash_q[0] + a_q;
          hash_q[1] <= hash_q[1] + b_q;
          hash_q[2] <= hash_q[2] + c_q;
          hash_q[3] <= hash_q[3] + d_q;
          hash_q[4] <= hash_q[4] + e_q;
        end
      end
    end
  end

  // Digest word select
  always_comb begin
    case (cmd_i.out_idx)
      3'd0:    digest_word_o = hash_q[0];
      3'd1:    digest_word_o = hash_q[1];
      3'd2:    digest_word_o = hash_q[2];
      3'd3:    digest_word_o = hash_q[3];
      default: digest_word_o = hash_q[4];
    endcase
  end

endmodule

`default_nettype wire

// File: src/sha1_message_hasher.sv
// Channel  | dir | tdata (low bit up)                    | tuser / tlast
// s_axis   | in  | data_byte[7:0]                        | tuser = kind
// m_axis   | out | digest_word[31:0], word_index[34:32] | tlast = last
//
// Bytes go in back to back; every 64th starts a compression (80 rounds in one
// round unit, then the hash fold). A finish request shifts padding and the
// length one byte a cycle between compressions, runs one or two compressions,
// then offers five words. Reset is asynchronous, active low, and loads the
// initial hash. Input is held off during compression, padding and output;
// output stalls freely. Top level: sha1_ctrl and sha1_dp, package sha1_pkg.
`default_nettype none

module sha1_message_hasher (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic        s_axis_tuser_i,   // [0] kind
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [39:0]      m_axis_tdata_o,   // [31:0] digest_word, [34:32] word_index
  output logic             m_axis_tlast_o
);

  sha1_pkg::cmd_t cmd;
  logic [5:0]     fill;
  logic [31:0]    digest_word;

  sha1_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .kind_i      (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .fill_i      (fill),
    .cmd_o       (cmd)
  );

  sha1_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (s_axis_tdata_i),
    .fill_o        (fill),
    .digest_word_o (digest_word)
  );

  // Result packing
  assign m_axis_tdata_o = {5'b00000, cmd.out_idx, digest_word};
  assign m_axis_tlast_o = (cmd.out_idx == sha1_pkg::WORD_LAST);

endmodule

`default_nettype wire

// File: verif/sha1_message_hasher_tb.sv
// Self-checking testbench for sha1_message_hasher: byte and finish requests in,
// digest words out, checked against a local SHA-1 predictor in queue order.
// Depends on sha1_pkg (kind codes, pad byte) and the sha1_message_hasher RTL.

module sha1_message_hasher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          DRAIN_CYCLES   = 200;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          ITEMS_PER_PH   = 60;

  // Known digests of the empty string and of "abc"
  localparam logic [159:0] DIGEST_EMPTY = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
  localparam logic [159:0] DIGEST_ABC   = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;

  localparam logic [31:0] SHA1_IV [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // Idle mix per phase: none, sender idle, receiver stall, both
  localparam int TX_IDLE_PCT  [4] = '{0, 60, 0, 16};
  localparam int RX_STALL_PCT [4] = '{0, 0, 60, 16};

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  pos;
    logic        last;
  } digest_word_t;

  typedef struct packed {
    logic         kind;
    logic [7:0]   data;
    logic         typed;   // digest below is the expected result
    logic [159:0] digest;
  } stim_row_t;

  localparam int DIR_ROWS = 12;
  localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
    // empty message, data ignored on finish
    '{sha1_pkg::KIND_FINISH, 8'hFF, 1'b1, DIGEST_EMPTY},
    '{sha1_pkg::KIND_BYTE,   8'h61, 1'b0, 160'h0},
    '{sha1_pkg::KIND_BYTE,   8'h62, 1'b0, 160'h0},
    '{sha1_pkg::KIND_BYTE,   8'h63, 1'b0, 160'h0},
    '{sha1_pkg::KIND_FINISH, 8'h00, 1'b1, DIGEST_ABC},
    '{sha1_pkg::KIND_BYTE,   8'h00, 1'b0, 160'h0},
    '{sha1_pkg::KIND_BYTE,   8'hFF, 1'b0, 160'h0},
    '{sha1_pkg::KIND_FINISH, 8'h00, 1'b0, 160'h0},
    // back to back finish: state must have returned to the initial hash
    '{sha1_pkg::KIND_FINISH, 8'h00, 1'b1, DIGEST_EMPTY},
    '{sha1_pkg::KIND_BYTE,   8'h80, 1'b0, 160'h0},
    '{sha1_pkg::KIND_BYTE,   8'h7F, 1'b0, 160'h0},
    '{sha1_pkg::KIND_FINISH, 8'h55, 1'b0, 160'h0}
  };

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic [7:0]  in_data   = 8'h00;
  logic        in_kind   = sha1_pkg::KIND_BYTE;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [39:0] out_data;
  logic        out_last;

  digest_word_t digest_q [$];
  int           fail_count   = 0;
  int           items_sent   = 0;
  int           tx_idle_pct  = 0;
  int           rx_stall_pct = 0;
  int           rx_hold_left = 0;

  // Predictor state
  logic [31:0] hash_st [5];
  logic [31:0] blk_st [16];
  int unsigned fill_st;
  logic [60:0] len_st;
  logic [31:0] digest_pred [5];

  sha1_message_hasher u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),    // [7:0] data_byte
    .s_axis_tuser_i  (in_kind),    // [0] kind
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data),   // [31:0] digest_word, [34:32] word_index
    .m_axis_tlast_o  (out_last)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void sha1_restart();
    for (int i = 0; i < 5; i++) hash_st[i] = SHA1_IV[i];
    fill_st = 0;
    len_st  = '0;
  endfunction

  function automatic void blk_put_byte(int unsigned slot, logic [7:0] v);
    blk_st[slot / 4][8 * (3 - slot % 4) +: 8] = v;
  endfunction

  function automatic void sha1_compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    for (int r = 0; r < 16; r++) w[r] = blk_st[r];
    for (int r = 16; r < 80; r++) begin
      x    = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
      w[r] = {x[30:0], x[31]};
    end
    a = hash_st[0];
    b = hash_st[1];
    c = hash_st[2];
    d = hash_st[3];
    e = hash_st[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5A827999;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9EBA1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62C1D6;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[r];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    hash_st[0] += a;
    hash_st[1] += b;
    hash_st[2] += c;
    hash_st[3] += d;
    hash_st[4] += e;
  endfunction

  // Absorb one request; returns the number of digest words it yields
  function automatic int sha1_absorb(logic kind, logic [7:0] b);
    logic [63:0] bits;
    int unsigned slot;
    if (kind == sha1_pkg::KIND_BYTE) begin
      blk_put_byte(fill_st, b);
      len_st  = len_st + 61'd1;
      fill_st = fill_st + 1;
      if (fill_st == 64) begin
        sha1_compress();
        fill_st = 0;
      end
      return 0;
    end
    bits = {len_st, 3'b000};
    slot = fill_st;
    blk_put_byte(slot, sha1_pkg::PAD_BYTE);
    for (int unsigned i = slot + 1; i < 64; i++) blk_put_byte(i, 8'h00);
    // no room left for the length field: spill into an extra block
    if (slot + 1 > 56) begin
      sha1_compress();
      for (int i = 0; i < 14; i++) blk_st[i] = '0;
    end
    blk_st[14] = bits[63:32];
    blk_st[15] = bits[31:0];
    sha1_compress();
    for (int i = 0; i < 5; i++) digest_pred[i] = hash_st[i];
    sha1_restart();
    return 5;
  endfunction

  // ------------------------------------------------------------------ sender

  task automatic send_req(input logic kind, input logic [7:0] data,
                          input logic typed, input logic [159:0] dig);
    int n;
    digest_word_t dw;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= data;
    in_kind  <= kind;
    do @(posedge clk_i); while (!in_ready);
    n = sha1_absorb(kind, data);
    for (int i = 0; i < n; i++) begin
      dw.word = typed ? dig[159 - 32*i -: 32] : digest_pred[i];
      dw.pos  = 3'(i);
      dw.last = (i == 4);
      digest_q.push_back(dw);
    end
    items_sent++;
  endtask

  task automatic send_message(input int len);
    for (int j = 0; j < len; j++)
      send_req(sha1_pkg::KIND_BYTE, 8'($urandom_range(255)), 1'b0, '0);
    send_req(sha1_pkg::KIND_FINISH, 8'($urandom_range(255)), 1'b0, '0);
  endtask

  // Mostly short messages, with a good share around the block boundaries
  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return $urandom_range(12);
    if (r < 85) begin
      case ($urandom_range(6))
        0:       return 55;
        1:       return 56;
        2:       return 57;
        3:       return 62;
        4:       return 63;
        5:       return 64;
        default: return 65;
      endcase
    end
    if (r < 95) return $urandom_range(54, 13);
    case ($urandom_range(3))
      0:       return 119;
      1:       return 120;
      2:       return 127;
      default: return 128;
    endcase
  endfunction

  // Pause the sender until every outstanding digest word has come back
  task automatic await_drain();
    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- receiver

  always @(posedge clk_i) begin
    if (rx_hold_left > 0) begin
      out_ready    <= 1'b0;
      rx_hold_left = rx_hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Compare each accepted digest word with the oldest expected one
  always @(posedge clk_i) begin
    digest_word_t exp_w;
    if (rst_ni && out_valid && out_ready) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest word %h index %0d last %b",
                 $time, out_data[31:0], out_data[34:32], out_last);
        fail_count++;
      end else begin
        exp_w = digest_q.pop_front();
        if (out_data[31:0] !== exp_w.word) begin
          $display("%0t: digest_word expected %h actual %h",
                   $time, exp_w.word, out_data[31:0]);
          fail_count++;
        end
        if (out_data[34:32] !== exp_w.pos) begin
          $display("%0t: word_index expected %0d actual %0d",
                   $time, exp_w.pos, out_data[34:32]);
          fail_count++;
        end
        if (out_last !== exp_w.last) begin
          $display("%0t: last expected %b actual %b", $time, exp_w.last, out_last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: too long without any request moving on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: watchdog, no traffic for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // -------------------------------------------------------------------- main

  initial begin
    int goal;
    sha1_restart();
    for (int i = 0; i < 16; i++) blk_st[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    for (int row = 0; row < DIR_ROWS; row++)
      send_req(DIR_TAB[row].kind, DIR_TAB[row].data, DIR_TAB[row].typed,
               DIR_TAB[row].digest);
    await_drain();

    // Long receiver hold while the sender keeps pushing: input must back up
    rx_hold_left = HOLD_CYCLES;
    send_message(6);
    send_message(9);
    await_drain();

    // Random messages under each idle mix
    for (int ph = 0; ph < 4; ph++) begin
      tx_idle_pct  = TX_IDLE_PCT[ph];
      rx_stall_pct = RX_STALL_PCT[ph];
      goal = items_sent + ITEMS_PER_PH;
      while (items_sent < goal) send_message(pick_len());
      await_drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && digest_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (digest_q.size() != 0)
        $display("%0t: %0d digest words never arrived", $time, digest_q.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
